@@ rtl/core/rmv_pkg.sv @@
// ----------------------------------------------------------------------------
// rmv_pkg
// Shared types and constants of the running mean and variance merge unit:
// widths of the shared shift-add / shift-subtract unit and its command format.
// ----------------------------------------------------------------------------
package rmv_pkg;

	localparam int MAX_FEATURES_DEF = 64;

	localparam int WIDE_W = 96;   // product accumulator / dividend shifter
	localparam int QUO_W  = 66;   // widest quotient (merged second moment / total)
	localparam int REM_W  = 33;   // remainder, holds anything below the total count
	localparam int MPL_W  = 33;   // multiplier shifter, msb first
	localparam int OPND_W = 64;   // multiplicand, or divisor in the low bits
	localparam int CNT_W  = 7;    // step count, up to QUO_W

	// shared unit operations
	localparam logic ALU_MUL = 1'b0;
	localparam logic ALU_DIV = 1'b1;

	typedef struct packed {
		logic              op;
		logic [CNT_W-1:0]  count;
		logic [WIDE_W-1:0] wide;
		logic [REM_W-1:0]  rem;
		logic [MPL_W-1:0]  mpl;
		logic [OPND_W-1:0] opnd;
	} rmv_cmd_t;

	typedef struct packed {
		logic              busy;
		logic [WIDE_W-1:0] wide;
		logic [QUO_W-1:0]  quo;
	} rmv_res_t;

endpackage

@@ rtl/core/rmv_in_if.sv @@
// ----------------------------------------------------------------------------
// rmv_in_if
// Input channel: one beat carries one feature's batch moments.
// ----------------------------------------------------------------------------
interface rmv_in_if;
	logic               valid;
	logic               ready;
	logic [5:0]         feature_index;
	logic signed [31:0] batch_mean_in;
	logic [31:0]        batch_variance_in;
	logic [15:0]        batch_size;

	modport source (
		output valid, feature_index, batch_mean_in, batch_variance_in, batch_size,
		input  ready
	);
	modport sink (
		input  valid, feature_index, batch_mean_in, batch_variance_in, batch_size,
		output ready
	);
endinterface

@@ rtl/core/rmv_out_if.sv @@
// ----------------------------------------------------------------------------
// rmv_out_if
// Result channel: one beat per accepted input beat.
// ----------------------------------------------------------------------------
interface rmv_out_if;
	logic               valid;
	logic               ready;
	logic [5:0]         feature_out;
	logic signed [31:0] new_mean;
	logic [31:0]        new_variance;
	logic [31:0]        merged_count;
	logic               count_committed;

	modport source (
		output valid, feature_out, new_mean, new_variance, merged_count, count_committed,
		input  ready
	);
	modport sink (
		input  valid, feature_out, new_mean, new_variance, merged_count, count_committed,
		output ready
	);
endinterface

@@ rtl/core/rmv_ram.sv @@
// ----------------------------------------------------------------------------
// rmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/rmv_alu.sv @@
// ----------------------------------------------------------------------------
// rmv_alu
// Shared iterative unit: msb-first shift-add multiply or restoring
// shift-subtract divide, one bit per cycle, for a commanded number of steps.
// ----------------------------------------------------------------------------
module rmv_alu
	import rmv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  rmv_cmd_t cmd,
	output rmv_res_t res
);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              op_q;
	logic [WIDE_W-1:0] wide_q;
	logic [REM_W-1:0]  rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [MPL_W-1:0]  mpl_q;
	logic [OPND_W-1:0] opnd_q;

	logic [WIDE_W-1:0] mul_add;
	logic [WIDE_W-1:0] mul_next;
	logic [REM_W:0]    trial;
	logic [REM_W+1:0]  diff;
	logic              qbit;
	logic [REM_W-1:0]  rem_next;

	always_comb begin
		mul_add  = mpl_q[MPL_W-1] ? {{(WIDE_W-OPND_W){1'b0}}, opnd_q} : '0;
		mul_next = {wide_q[WIDE_W-2:0], 1'b0} + mul_add;
		// trial subtract of the divisor from the remainder with the next dividend bit
		trial    = {rem_q, wide_q[WIDE_W-1]};
		diff     = {1'b0, trial} - {2'b00, opnd_q[REM_W-1:0]};
		qbit     = !diff[REM_W+1];
		rem_next = qbit ? diff[REM_W-1:0] : trial[REM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= cmd.op;
			wide_q <= cmd.wide;
			rem_q  <= cmd.rem;
			mpl_q  <= cmd.mpl;
			opnd_q <= cmd.opnd;
			quo_q  <= '0;
		end else if (busy_q) begin
			unique case (op_q)
				ALU_MUL: begin
					wide_q <= mul_next;
					mpl_q  <= {mpl_q[MPL_W-2:0], 1'b0};
				end
				ALU_DIV: begin
					wide_q <= {wide_q[WIDE_W-2:0], 1'b0};
					rem_q  <= rem_next;
					quo_q  <= {quo_q[QUO_W-2:0], qbit};
				end
				default: begin
					wide_q <= wide_q;
				end
			endcase
		end
	end

	assign res.busy = busy_q;
	assign res.wide = wide_q;
	assign res.quo  = quo_q;

endmodule

@@ rtl/core/running_mean_variance_merge_unit.sv @@
// ----------------------------------------------------------------------------
// running_mean_variance_merge_unit
// Per-feature running mean and population variance with a shared sample
// count, merged one batch at a time (parallel variance rule, Q16.16).
// ----------------------------------------------------------------------------
// in_ch beat: feature_index, batch_mean_in, batch_variance_in, batch_size.
// out_ch beat: feature_out, new_mean, new_variance, merged_count,
// count_committed; exactly one result beat for every input beat, in order.
// cfg_we/cfg_wdata write feature_count; write it only while the block is idle.
// The beat for feature feature_count-1 (0 read as 1, above MAX_FEATURES as
// MAX_FEATURES) stores the merged count, which all features merge against.
// Each item runs nine multiply and divide passes (32,16,32,64,32,16,66,16,48
// steps) through one shift-add / shift-subtract unit at one bit per cycle,
// plus fetch and finish; the next beat is accepted only once the item is done.
// A beat with zero count and zero batch size skips the passes and goes from
// fetch straight to finish.
// After reset the feature store is cleared, one entry a cycle, and
// in_ch.ready stays low meanwhile.
// The result sits in an output register: a stalled receiver holds it there,
// the next item is still taken, and the block waits at its end until the
// register frees up.
// ----------------------------------------------------------------------------
module running_mean_variance_merge_unit
	import rmv_pkg::*;
#(
	parameter int MAX_FEATURES = MAX_FEATURES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rmv_in_if.sink     in_ch,
	rmv_out_if.source  out_ch,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata
);

	localparam int FIDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CW     = (FIDX_W + 1 > 7) ? FIDX_W + 1 : 7;

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_READ  = 4'd2;
	localparam logic [3:0] ST_SQ    = 4'd3;
	localparam logic [3:0] W_SQ     = 4'd4;
	localparam logic [3:0] W_Y      = 4'd5;
	localparam logic [3:0] W_P      = 4'd6;
	localparam logic [3:0] W_CROSS  = 4'd7;
	localparam logic [3:0] W_P1     = 4'd8;
	localparam logic [3:0] W_P2     = 4'd9;
	localparam logic [3:0] W_VAR    = 4'd10;
	localparam logic [3:0] W_MD     = 4'd11;
	localparam logic [3:0] W_MEAN   = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	function automatic logic [5:0] wrap_idx(input logic [5:0] idx);
		logic [16:0] r;
		logic [16:0] lim;
		r = {11'b0, idx};
		for (int k = 5; k >= 0; k--) begin
			lim = 17'(MAX_FEATURES) << k;
			if (r >= lim) begin
				r = r - lim;
			end
		end
		return r[5:0];
	endfunction

	// control state
	logic [3:0]        state_q, state_d;
	logic [FIDX_W-1:0] clr_q;
	logic [31:0]       sample_count_q;
	logic [6:0]        feature_count_q;
	logic              out_valid_q;

	// item payload
	logic [5:0]        f_q;
	logic [31:0]       bm_q;
	logic [31:0]       bv_q;
	logic [15:0]       b_q;
	logic [31:0]       m_q;
	logic [31:0]       v_q;
	logic [32:0]       tot_q;
	logic [31:0]       ad_q;
	logic              dneg_q;
	logic [63:0]       cross_q;
	logic [64:0]       sum_q;
	logic [31:0]       var_q;
	logic [31:0]       mean_q;

	// output register
	logic [5:0]        o_feat_q;
	logic [31:0]       o_mean_q;
	logic [31:0]       o_var_q;
	logic [31:0]       o_cnt_q;
	logic              o_commit_q;

	// shared unit
	logic              alu_start;
	rmv_cmd_t          alu_cmd;
	rmv_res_t          alu_res;

	// store
	logic              ram_we;
	logic [FIDX_W-1:0] ram_waddr;
	logic [63:0]       ram_wdata;
	logic [FIDX_W-1:0] ram_raddr;
	logic [63:0]       ram_rdata;

	logic              in_fire;
	logic              out_free;
	logic [32:0]       delta, ndelta;
	logic [32:0]       tot;
	logic [65:0]       m2;
	logic [33:0]       qmag, qsig, mean_sum;
	logic [31:0]       var_sat;
	logic [31:0]       merged;
	logic [CW-1:0]     fc_ext, last;
	logic              commit;

	rmv_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (alu_start),
		.cmd    (alu_cmd),
		.res    (alu_res)
	);

	rmv_ram #(
		.WIDTH (64),
		.DEPTH (MAX_FEATURES)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;
	assign ram_raddr   = FIDX_W'(wrap_idx(in_ch.feature_index));

	assign delta  = {bm_q[31], bm_q} - {ram_rdata[63], ram_rdata[63:32]};
	assign ndelta = -delta;
	assign tot    = {1'b0, sample_count_q} + {17'b0, b_q};

	// merged second moment: v*n + bv*b + cross
	assign m2 = {1'b0, sum_q} + {18'b0, alu_res.wide[47:0]};

	assign var_sat = (alu_res.quo[65:32] != '0) ? '1 : alu_res.quo[31:0];

	// mean step: m + sign * floor(|delta| * b / T)
	assign qmag     = {1'b0, alu_res.quo[32:0]};
	assign qsig     = dneg_q ? -qmag : qmag;
	assign mean_sum = {{2{m_q[31]}}, m_q} + qsig;

	assign merged = tot_q[32] ? '1 : tot_q[31:0];
	assign fc_ext = CW'(feature_count_q);
	assign last   = (fc_ext == '0) ? CW'(1) :
	                (fc_ext > CW'(MAX_FEATURES)) ? CW'(MAX_FEATURES) : fc_ext;
	assign commit = (CW'(f_q) == last - CW'(1));

	always_comb begin
		state_d   = state_q;
		alu_start = 1'b0;
		alu_cmd   = '0;
		ram_we    = 1'b0;
		ram_waddr = FIDX_W'(f_q);
		ram_wdata = {mean_sum[31:0], var_q};
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				if (clr_q == FIDX_W'(MAX_FEATURES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = (tot == '0) ? ST_DONE : ST_SQ;
			end
			ST_SQ: begin
				alu_start     = 1'b1;
				alu_cmd.op    = ALU_MUL;
				alu_cmd.count = CNT_W'(32);
				alu_cmd.mpl   = {ad_q, 1'b0};
				alu_cmd.opnd  = {32'b0, ad_q};
				state_d       = W_SQ;
			end
			W_SQ: begin
				// d2 = delta^2 >> 16, times b
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_MUL;
					alu_cmd.count = CNT_W'(16);
					alu_cmd.mpl   = {b_q, 17'b0};
					alu_cmd.opnd  = {16'b0, alu_res.wide[63:16]};
					state_d       = W_Y;
				end
			end
			W_Y: begin
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_MUL;
					alu_cmd.count = CNT_W'(32);
					alu_cmd.mpl   = {sample_count_q, 1'b0};
					alu_cmd.opnd  = alu_res.wide[63:0];
					state_d       = W_P;
				end
			end
			W_P: begin
				// quotient fits 64 bits, so the top word goes straight into the remainder
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_DIV;
					alu_cmd.count = CNT_W'(64);
					alu_cmd.rem   = {1'b0, alu_res.wide[95:64]};
					alu_cmd.wide  = {alu_res.wide[63:0], 32'b0};
					alu_cmd.opnd  = {31'b0, tot_q};
					state_d       = W_CROSS;
				end
			end
			W_CROSS: begin
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_MUL;
					alu_cmd.count = CNT_W'(32);
					alu_cmd.mpl   = {sample_count_q, 1'b0};
					alu_cmd.opnd  = {32'b0, v_q};
					state_d       = W_P1;
				end
			end
			W_P1: begin
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_MUL;
					alu_cmd.count = CNT_W'(16);
					alu_cmd.mpl   = {b_q, 17'b0};
					alu_cmd.opnd  = {32'b0, bv_q};
					state_d       = W_P2;
				end
			end
			W_P2: begin
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_DIV;
					alu_cmd.count = CNT_W'(66);
					alu_cmd.wide  = {m2, 30'b0};
					alu_cmd.opnd  = {31'b0, tot_q};
					state_d       = W_VAR;
				end
			end
			W_VAR: begin
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_MUL;
					alu_cmd.count = CNT_W'(16);
					alu_cmd.mpl   = {b_q, 17'b0};
					alu_cmd.opnd  = {32'b0, ad_q};
					state_d       = W_MD;
				end
			end
			W_MD: begin
				if (!alu_res.busy) begin
					alu_start     = 1'b1;
					alu_cmd.op    = ALU_DIV;
					alu_cmd.count = CNT_W'(48);
					alu_cmd.wide  = {alu_res.wide[47:0], 48'b0};
					alu_cmd.opnd  = {31'b0, tot_q};
					state_d       = W_MEAN;
				end
			end
			W_MEAN: begin
				if (!alu_res.busy) begin
					ram_we  = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_CLEAR;
			clr_q           <= '0;
			sample_count_q  <= '0;
			feature_count_q <= 7'd64;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + FIDX_W'(1);
			end
			if (cfg_we) begin
				feature_count_q <= cfg_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
				if (commit) begin
					sample_count_q <= merged;
				end
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			f_q  <= wrap_idx(in_ch.feature_index);
			bm_q <= in_ch.batch_mean_in;
			bv_q <= in_ch.batch_variance_in;
			b_q  <= in_ch.batch_size;
		end
		if (state_q == ST_READ) begin
			m_q    <= ram_rdata[63:32];
			v_q    <= ram_rdata[31:0];
			mean_q <= ram_rdata[63:32];
			var_q  <= ram_rdata[31:0];
			tot_q  <= tot;
			dneg_q <= delta[32];
			ad_q   <= delta[32] ? ndelta[31:0] : delta[31:0];
		end
		if (state_q == W_CROSS && !alu_res.busy) begin
			cross_q <= alu_res.quo[63:0];
		end
		if (state_q == W_P1 && !alu_res.busy) begin
			sum_q <= {1'b0, alu_res.wide[63:0]} + {1'b0, cross_q};
		end
		if (state_q == W_VAR && !alu_res.busy) begin
			var_q <= var_sat;
		end
		if (state_q == W_MEAN && !alu_res.busy) begin
			mean_q <= mean_sum[31:0];
		end
		if (state_q == ST_DONE && out_free) begin
			o_feat_q   <= f_q;
			o_mean_q   <= mean_q;
			o_var_q    <= var_q;
			o_cnt_q    <= merged;
			o_commit_q <= commit;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.feature_out     = o_feat_q;
	assign out_ch.new_mean        = o_mean_q;
	assign out_ch.new_variance    = o_var_q;
	assign out_ch.merged_count    = o_cnt_q;
	assign out_ch.count_committed = o_commit_q;

`ifndef SYNTHESIS
	a_ready_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !alu_res.busy)
		else $error("input taken while the shared unit is busy");

	a_start_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alu_start |-> !alu_res.busy)
		else $error("shared unit restarted mid-pass");

	a_count_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sample_count_q) |-> $past(state_q == ST_DONE) && out_valid_q)
		else $error("sample count changed outside a result beat");

	a_store_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_CLEAR || state_q == W_MEAN))
		else $error("feature store written out of sequence");
`endif

endmodule

@@ bench/moment_merge_check.sv @@
// ----------------------------------------------------------------------------
// moment_merge_check
// Watches the batch and result channels of the merge unit, keeps its own copy
// of the per-feature mean / variance store and the shared count, predicts
// each result when a batch beat is taken and compares it field by field with
// the result beats in order.
// ----------------------------------------------------------------------------
module moment_merge_check
	import rmv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rmv_in_if           in_ch,
	rmv_out_if          out_ch,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output int unsigned failures,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FEATURES = MAX_FEATURES_DEF;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic [5:0]         feature;
		logic signed [31:0] mean;
		logic [31:0]        variance;
		logic [31:0]        count;
		logic               committed;
	} merge_result_t;

	logic signed [31:0] mean_q [FEATURES];
	logic [31:0]        var_q [FEATURES];
	logic [31:0]        count_q;
	logic [6:0]         feature_count_q;

	merge_result_t predicted_merges [$];
	int unsigned   fail_cnt;
	int unsigned   result_cnt;

	// parallel variance merge of one batch into the stored moments
	function automatic merge_result_t merge_batch(input logic [5:0] idx,
			input logic signed [31:0] bmean, input logic [31:0] bvar,
			input logic [15:0] bsize);
		int            f;
		int            last;
		logic [32:0]   n;
		logic [32:0]   total;
		longint        delta;
		longint        step;
		logic [127:0]  mag;
		logic [127:0]  d2;
		logic [127:0]  y;
		logic [127:0]  cross_term;
		logic [127:0]  m2;
		logic [127:0]  quot;
		merge_result_t r;

		f = int'(idx) % FEATURES;
		n = {1'b0, count_q};
		total = n + bsize;
		if (total != 0) begin
			delta = longint'(bmean) - longint'(mean_q[f]);
			mag = (delta < 0) ? 128'(-delta) : 128'(delta);
			// delta squared back in Q16.16
			d2 = (mag * mag) >> 16;
			y = d2 * bsize;
			cross_term = (y * n) / total;
			m2 = var_q[f] * n + bvar * bsize + cross_term;
			quot = m2 / total;
			step = (delta * longint'(bsize)) / longint'(total);
			mean_q[f] = 32'(longint'(mean_q[f]) + step);
			var_q[f] = (quot > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
		end

		r.count = (total > 33'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
		if (feature_count_q == 0)
			last = 1;
		else if (feature_count_q > FEATURES)
			last = FEATURES;
		else
			last = int'(feature_count_q);
		r.committed = (f == last - 1);
		if (r.committed)
			count_q = r.count;
		r.feature = 6'(f);
		r.mean = mean_q[f];
		r.variance = var_q[f];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		merge_result_t got;
		merge_result_t want;
		logic          bad;
		int            i;

		if (!arst_n) begin
			for (i = 0; i < FEATURES; i++) begin
				mean_q[i] = '0;
				var_q[i] = '0;
			end
			count_q = '0;
			feature_count_q = 7'd64;
			predicted_merges.delete();
			fail_cnt = 0;
			result_cnt = 0;
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_we)
				feature_count_q = cfg_wdata;

			// results first: a beat taken this edge cannot have its result yet
			if (out_ch.valid && out_ch.ready) begin
				got.feature = out_ch.feature_out;
				got.mean = out_ch.new_mean;
				got.variance = out_ch.new_variance;
				got.count = out_ch.merged_count;
				got.committed = out_ch.count_committed;
				result_cnt++;
				if (predicted_merges.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_MAX)
						$display("%0t: result beat %0d arrived with nothing predicted",
							$realtime, result_cnt);
				end else begin
					want = predicted_merges.pop_front();
					bad = (got.feature !== want.feature) || (got.mean !== want.mean) ||
						(got.variance !== want.variance) || (got.count !== want.count) ||
						(got.committed !== want.committed);
					if (bad) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_MAX) begin
							$display("%0t: result %0d mismatch", $realtime, result_cnt);
							$display("  exp feat=%0d mean=%h var=%h count=%h commit=%b",
								want.feature, want.mean, want.variance, want.count,
								want.committed);
							$display("  got feat=%0d mean=%h var=%h count=%h commit=%b",
								got.feature, got.mean, got.variance, got.count,
								got.committed);
						end
					end
				end
			end

			if (in_ch.valid && in_ch.ready)
				predicted_merges.push_back(merge_batch(in_ch.feature_index,
					in_ch.batch_mean_in, in_ch.batch_variance_in, in_ch.batch_size));

			pending <= predicted_merges.size();
			failures <= fail_cnt;
		end
	end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the running mean / variance merge unit: directed batches at the
// field extremes and the special cases, then random sweeps over the features
// under several feature_count settings, with random gaps on both channels,
// one long result hold-off and full drains mid-run. Checking is done by
// moment_merge_check.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rmv_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 1500;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;
	int unsigned failures;
	int unsigned pending;
	int unsigned quiet_cycles = 0;
	bit          full_rate = 1'b0;
	bit          hold_req = 1'b0;

	rmv_in_if  in_bus();
	rmv_out_if out_bus();

	always #5ns clk = ~clk;

	running_mean_variance_merge_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	moment_merge_check u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_bus),
		.out_ch    (out_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.failures  (failures),
		.pending   (pending)
	);

	// offers one batch beat after a random gap, returns at the accepting edge
	task automatic send_batch(input logic [5:0] f, input logic [31:0] mean,
			input logic [31:0] vr, input logic [15:0] sz);
		int gap;
		gap = full_rate ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid <= 1'b1;
		in_bus.feature_index <= f;
		in_bus.batch_mean_in <= mean;
		in_bus.batch_variance_in <= vr;
		in_bus.batch_size <= sz;
		do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
	endtask

	task automatic random_batch(input logic [5:0] f);
		logic [31:0] mean;
		logic [31:0] vr;
		logic [15:0] sz;
		case ($urandom_range(0, 5))
			0: mean = $urandom;
			1: mean = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: mean = 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		endcase
		vr = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
		case ($urandom_range(0, 19))
			0: sz = '0;
			1, 2: sz = 16'hFFFF;
			3, 4, 5, 6, 7: sz = 16'($urandom_range(1, 64));
			default: sz = 16'($urandom_range(1, 65535));
		endcase
		send_batch(f, mean, vr, sz);
	endtask

	// stop offering and wait until every predicted result has been taken
	task automatic drain();
		in_bus.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_feature_count(input logic [6:0] fc);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= fc;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly in-order sweeps over the features in use, some stray features
	task automatic run_batches(input logic [6:0] fc, input int budget);
		int last;
		int sent;
		int fi;
		if (fc == 0)
			last = 1;
		else if (fc > MAX_FEATURES_DEF)
			last = MAX_FEATURES_DEF;
		else
			last = int'(fc);
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 4) != 0) begin
				for (fi = 0; fi < last && sent < budget; fi++) begin
					random_batch(6'(fi));
					sent++;
				end
			end else begin
				random_batch(6'($urandom_range(0, 63)));
				sent++;
			end
		end
	endtask

	task automatic random_phase(input logic [6:0] fc, input int budget);
		set_feature_count(fc);
		run_batches(fc, budget);
	endtask

	// result side: random stall per beat, one long hold-off on request
	initial begin : receiver
		int stall;
		out_bus.ready <= 1'b0;
		forever begin
			stall = full_rate ? 0 : $urandom_range(0, 4);
			if (hold_req) begin
				stall = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall != 0) begin
				out_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_bus.ready <= 1'b1;
			do @(posedge clk); while (!(out_bus.valid && out_bus.ready));
		end
	end

	always @(posedge clk) begin
		if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_bus.valid <= 1'b0;
		in_bus.feature_index <= '0;
		in_bus.batch_mean_in <= '0;
		in_bus.batch_variance_in <= '0;
		in_bus.batch_size <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// first batches land on a zero count and are copied in
		send_batch(6'd0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd1);
		send_batch(6'd1, 32'h8000_0000, 32'h0000_0000, 16'hFFFF);
		// empty batch on zero count
		send_batch(6'd2, 32'h0000_0000, 32'h1234_5678, 16'd0);
		send_batch(6'd63, 32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF);
		// full-scale delta, variance saturates
		send_batch(6'd0, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
		send_batch(6'd1, 32'h7FFF_FFFF, 32'h0001_0000, 16'd1);
		// empty batches against a nonzero count, one of them committing
		send_batch(6'd2, 32'h0001_8000, 32'h0000_0000, 16'd0);
		send_batch(6'd63, 32'h0000_0000, 32'h0000_0000, 16'd0);
		send_batch(6'd3, 32'hFFFF_0000, 32'h0002_0000, 16'h8000);

		set_feature_count(7'd1);
		send_batch(6'd0, 32'h0003_0000, 32'h0000_8000, 16'd100);
		send_batch(6'd0, 32'hFFFD_0000, 32'h0010_0000, 16'd7);
		send_batch(6'd63, 32'h0000_4000, 32'h0000_0100, 16'd5);

		// zero acts as one feature
		set_feature_count(7'd0);
		send_batch(6'd0, 32'h0000_1000, 32'h0000_0010, 16'd3);
		send_batch(6'd1, 32'h0020_0000, 32'h0001_0000, 16'd9);

		// above the feature limit acts as the limit
		set_feature_count(7'd127);
		send_batch(6'd63, 32'hFFFF_8000, 32'h0000_2000, 16'd11);
		send_batch(6'd62, 32'h0005_0000, 32'h0003_0000, 16'd13);

		random_phase(7'd64, 70);
		random_phase(7'd1, 40);

		full_rate = 1'b1;
		random_phase(7'd2, 40);
		full_rate = 1'b0;

		// receiver holds off while batches keep coming, the unit backs up
		set_feature_count(7'd7);
		hold_req = 1'b1;
		run_batches(7'd7, 50);

		random_phase(7'd0, 30);
		random_phase(7'd127, 70);

		set_feature_count(7'd33);
		run_batches(7'd33, 20);
		drain();
		run_batches(7'd33, 30);

		random_phase(7'($urandom_range(1, 64)), 50);

		drain();
		repeat (END_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
